/* rtl/core/clir_pkg.sv */
// ----------------------------------------------------------------------------
// clir_pkg
// Types and constants shared by the line rasterizer core.
// ----------------------------------------------------------------------------
package clir_pkg;

   localparam int unsigned COORD_W = 6;
   localparam int unsigned COLOR_W = 8;
   localparam int unsigned OFFS_W  = 14;
   localparam int unsigned BYTES_PER_PIXEL_SHIFT = 2;

   // line command as accepted on the request channel
   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COLOR_W-1:0] start_red;
      logic [COLOR_W-1:0] start_green;
      logic [COLOR_W-1:0] start_blue;
      logic [COLOR_W-1:0] start_alpha;
      logic [COLOR_W-1:0] end_red;
      logic [COLOR_W-1:0] end_green;
      logic [COLOR_W-1:0] end_blue;
      logic [COLOR_W-1:0] end_alpha;
   } line_cmd_type;

   // one rasterized pixel
   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [OFFS_W-1:0]  byte_offset;
      logic [COLOR_W-1:0] pixel_red;
      logic [COLOR_W-1:0] pixel_green;
      logic [COLOR_W-1:0] pixel_blue;
      logic [COLOR_W-1:0] pixel_alpha;
      logic               last_pixel;
   } pixel_type;

   // classified line, handed from front end to back end
   typedef struct packed {
      logic                      steep;
      logic                      minor_neg;
      logic [COORD_W-1:0]        x0;
      logic [COORD_W-1:0]        y0;
      logic [COORD_W-1:0]        major;
      logic [COORD_W-1:0]        minor;
      logic [2:0][COLOR_W-1:0]   c0;
      logic [2:0][COLOR_W:0]     diff;   // signed end - start
      logic [COLOR_W-1:0]        alpha;
   } setup_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_DIV,
      BE_EMIT
   } be_state_type;

endpackage

/* rtl/core/clir_stream_if.sv */
// ----------------------------------------------------------------------------
// clir_stream_if
// Valid/ready channel carrying one payload type.
// ----------------------------------------------------------------------------
interface clir_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/clir_front.sv */
// ----------------------------------------------------------------------------
// clir_front
// Classify a line command (octant, ordering) into a registered setup record.
// ----------------------------------------------------------------------------
module clir_front (
   input  logic                 clock,
   input  logic                 reset,
   clir_stream_if.sink          req,
   output logic                 setup_valid,
   output clir_pkg::setup_type  setup,
   input  logic                 setup_ready
);
   localparam int unsigned CW = clir_pkg::COORD_W;

   logic                valid_ff, valid_in;
   clir_pkg::setup_type setup_ff, setup_in;

   logic [CW:0] sdx, sdy, adx, ady;
   logic        steep, swap;
   clir_pkg::line_cmd_type c;

   // classify the incoming command
   always_comb begin
      c     = req.data;
      sdx   = {1'b0, c.end_x} - {1'b0, c.start_x};
      sdy   = {1'b0, c.end_y} - {1'b0, c.start_y};
      adx   = sdx[CW] ? (~sdx + 1'b1) : sdx;
      ady   = sdy[CW] ? (~sdy + 1'b1) : sdy;
      steep = !(ady < adx);
      swap  = steep ? sdy[CW] : sdx[CW];
      setup_in.steep = steep;
      setup_in.x0    = swap ? c.end_x : c.start_x;
      setup_in.y0    = swap ? c.end_y : c.start_y;
      setup_in.major = steep ? ady[CW-1:0] : adx[CW-1:0];
      setup_in.minor = steep ? adx[CW-1:0] : ady[CW-1:0];
      // minor direction after ordering: sign flips with the swap
      setup_in.minor_neg = (steep ? sdx[CW] : sdy[CW]) ^ swap;
      if ((steep ? adx : ady) == '0) setup_in.minor_neg = 1'b0;
      setup_in.alpha = swap ? c.end_alpha : c.start_alpha;
      setup_in.c0[0] = swap ? c.end_red   : c.start_red;
      setup_in.c0[1] = swap ? c.end_green : c.start_green;
      setup_in.c0[2] = swap ? c.end_blue  : c.start_blue;
      setup_in.diff[0] = swap ? ({1'b0, c.start_red}   - {1'b0, c.end_red})
                              : ({1'b0, c.end_red}     - {1'b0, c.start_red});
      setup_in.diff[1] = swap ? ({1'b0, c.start_green} - {1'b0, c.end_green})
                              : ({1'b0, c.end_green}   - {1'b0, c.start_green});
      setup_in.diff[2] = swap ? ({1'b0, c.start_blue}  - {1'b0, c.end_blue})
                              : ({1'b0, c.end_blue}    - {1'b0, c.start_blue});
   end

   assign req.ready = !valid_ff || setup_ready;

   // hold the setup record until the back end takes it
   always_comb begin
      valid_in = valid_ff;
      if (req.ready) valid_in = req.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (req.valid && req.ready) setup_ff <= setup_in;
   end

   assign setup_valid = valid_ff;
   assign setup       = setup_ff;

   a_major_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (setup_ff.minor <= setup_ff.major))
      else $error("minor exceeds major");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !setup_ready) |=> (valid_ff && $stable(setup_ff.major)))
      else $error("setup dropped while stalled");
   a_zero_steep: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && setup_ff.major == '0) |-> setup_ff.steep)
      else $error("zero-length line not steep");
endmodule

/* rtl/core/clir_back.sv */
// ----------------------------------------------------------------------------
// clir_back
// Divide color differences, step Bresenham; one pixel a cycle unless stalled.
// ----------------------------------------------------------------------------
module clir_back #(
   parameter int unsigned TILE_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 setup_valid,
   input  clir_pkg::setup_type  setup,
   output logic                 setup_ready,
   clir_stream_if.source        rsp
);
   localparam int unsigned CW = clir_pkg::COORD_W;
   localparam int unsigned KW = clir_pkg::COLOR_W;
   localparam int unsigned OW = clir_pkg::OFFS_W;
   localparam int unsigned EW = CW + 3;            // signed error term
   localparam int unsigned QB = $clog2(KW + 1);

   clir_pkg::be_state_type state_ff, state_in;
   clir_pkg::setup_type    job_ff, job_in;

   // restoring dividers, one quotient bit per cycle, three in parallel
   logic [KW-1:0] rem_ff [3], rem_in [3];
   logic [KW-1:0] quo_ff [3], quo_in [3];
   logic [QB-1:0] bit_ff, bit_in;

   logic [CW-1:0] px_ff, px_in, py_ff, py_in, cnt_ff, cnt_in;
   logic [EW-1:0] err_ff, err_in;
   logic [KW-1:0] cur_ff [3], cur_in [3];
   logic [KW:0]   inc [3];

   logic           out_valid_ff, out_valid_in;
   clir_pkg::pixel_type out_ff, out_in;
   logic           out_free;
   logic [KW:0]    mag [3];
   logic [KW:0]    trial [3];
   logic [OW-1:0]  offs;

   assign out_free    = !out_valid_ff || rsp.ready;
   assign setup_ready = (state_ff == clir_pkg::BE_IDLE);

   // signed increment from magnitude quotient
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k] = job_ff.diff[k][KW] ? (~job_ff.diff[k] + 1'b1) : job_ff.diff[k];
         inc[k] = job_ff.diff[k][KW] ? (~{1'b0, quo_ff[k]} + 1'b1) : {1'b0, quo_ff[k]};
         trial[k] = {rem_ff[k], mag[k][bit_ff[QB-1:0] - 1'b1]};
      end
      offs = OW'((OW'(py_ff) * OW'(TILE_WIDTH) + OW'(px_ff))
             << clir_pkg::BYTES_PER_PIXEL_SHIFT);
   end

   // sequencer: next state, datapath updates and output register
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in       = out_ff;
      case (state_ff)
         clir_pkg::BE_IDLE: begin
            if (setup_valid) begin
               job_in   = setup;
               px_in    = setup.x0;
               py_in    = setup.y0;
               cnt_in   = '0;
               err_in   = EW'({setup.minor, 1'b0}) - EW'(setup.major);
               for (int k = 0; k < 3; k++) begin
                  cur_in[k] = setup.c0[k];
                  rem_in[k] = '0;
                  quo_in[k] = '0;
               end
               bit_in   = QB'(KW);
               state_in = (setup.major == '0) ? clir_pkg::BE_EMIT : clir_pkg::BE_DIV;
            end
         end
         clir_pkg::BE_DIV: begin
            // one quotient bit per channel, MSB first
            for (int k = 0; k < 3; k++) begin
               if (trial[k] >= {3'b000, job_ff.major}) begin
                  rem_in[k] = KW'(trial[k] - {3'b000, job_ff.major});
                  quo_in[k] = {quo_ff[k][KW-2:0], 1'b1};
               end else begin
                  rem_in[k] = KW'(trial[k]);
                  quo_in[k] = {quo_ff[k][KW-2:0], 1'b0};
               end
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == QB'(1)) state_in = clir_pkg::BE_EMIT;
         end
         clir_pkg::BE_EMIT: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.pixel_x     = px_ff;
               out_in.pixel_y     = py_ff;
               out_in.byte_offset = offs;
               out_in.pixel_red   = cur_ff[0];
               out_in.pixel_green = cur_ff[1];
               out_in.pixel_blue  = cur_ff[2];
               out_in.pixel_alpha = job_ff.alpha;
               out_in.last_pixel  = (cnt_ff == job_ff.major);
               // advance color and Bresenham step
               for (int k = 0; k < 3; k++)
                  cur_in[k] = KW'({1'b0, cur_ff[k]} + inc[k]);
               err_in = err_ff;
               if (!err_ff[EW-1] && err_ff != '0) begin
                  if (job_ff.steep)
                     px_in = job_ff.minor_neg ? px_ff - 1'b1 : px_ff + 1'b1;
                  else
                     py_in = job_ff.minor_neg ? py_ff - 1'b1 : py_ff + 1'b1;
                  err_in = err_in - EW'({job_ff.major, 1'b0});
               end
               err_in = err_in + EW'({job_ff.minor, 1'b0});
               if (job_ff.steep) py_in = py_in + 1'b1;
               else              px_in = px_in + 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == job_ff.major) state_in = clir_pkg::BE_IDLE;
            end
         end
         default: state_in = clir_pkg::BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clir_pkg::BE_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff <= job_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      cnt_ff <= cnt_in;
      err_ff <= err_in;
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clir_pkg::BE_EMIT) |-> (cnt_ff <= job_ff.major))
      else $error("pixel count past major length");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (setup_valid && setup_ready) |=> (state_ff != clir_pkg::BE_IDLE))
      else $error("setup taken without starting");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clir_pkg::BE_EMIT && out_free && cnt_ff == job_ff.major)
      |=> (state_ff == clir_pkg::BE_IDLE && out_ff.last_pixel))
      else $error("last pixel did not end the line");
endmodule

/* rtl/core/color_interpolating_line_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// color_interpolating_line_rasterizer_core
// Bresenham line rasterizer with per-pixel RGB interpolation.
//
//   channel  dir  payload                          handshake
//   req      in   line_cmd_type (ends + RGBA)      req_valid / req_ready
//   rsp      out  pixel_type (x, y, offset, RGBA)  rsp_valid / rsp_ready
//
// A line of major length N passes through setup, the dividers (skipped
// when N is 0) and the emission of N+1 pixels; the three parallel restoring
// dividers, one quotient bit a cycle, set the setup time.
// The front register takes the next command while one draws.
// Reset is synchronous and clears only control state. A stalled rsp holds
// the pixel in the output register and freezes the stepper.
// ----------------------------------------------------------------------------
module color_interpolating_line_rasterizer_core #(
   parameter int unsigned TILE_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  clir_pkg::line_cmd_type    req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output clir_pkg::pixel_type       rsp_data
);
   clir_stream_if #(.payload_type(clir_pkg::line_cmd_type)) req_ch ();
   clir_stream_if #(.payload_type(clir_pkg::pixel_type))    rsp_ch ();

   logic                setup_valid, setup_ready;
   clir_pkg::setup_type setup;

   assign req_ch.valid = req_valid;
   assign req_ch.data  = req_data;
   assign req_ready    = req_ch.ready;
   assign rsp_valid    = rsp_ch.valid;
   assign rsp_data     = rsp_ch.data;
   assign rsp_ch.ready = rsp_ready;

   clir_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch.sink),
      .setup_valid (setup_valid),
      .setup       (setup),
      .setup_ready (setup_ready)
   );

   clir_back #(.TILE_WIDTH(TILE_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .setup_valid (setup_valid),
      .setup       (setup),
      .setup_ready (setup_ready),
      .rsp         (rsp_ch.source)
   );
endmodule
